>>> rtl/core/tour_segment_reversal_defines.svh
// Assertion macros for the tour segment reversal checker.
// Depends on a clk and an active-low arst_n in the scope of use.
`ifndef TOUR_SEGMENT_REVERSAL_DEFINES_SVH
`define TOUR_SEGMENT_REVERSAL_DEFINES_SVH

// same-cycle implication
`define TSR_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TSR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/tsr_pkg.sv
// Types, constants and codes for the tour segment reversal block.
// No dependencies.
`timescale 1ns / 1ps

package tsr_pkg;

	localparam int MAX_CITIES = 1024;
	localparam int TBL_DEPTH  = MAX_CITIES + 1;
	localparam int FIELD_W    = 11;
	localparam int IDX_W      = $clog2(TBL_DEPTH);

	typedef logic [FIELD_W-1:0] field_t;
	typedef logic [IDX_W-1:0]   idx_t;

	localparam field_t MAX_FIELD = field_t'(MAX_CITIES);

	typedef enum logic [1:0] {
		MODE_LOAD    = 2'd0,
		MODE_REVERSE = 2'd1,
		MODE_QUERY   = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_REV_INIT,
		ST_SWAP_RD,
		ST_SWAP_WL,
		ST_SWAP_WH,
		ST_INV,
		ST_RES_RD,
		ST_RES_CAP
	} state_t;

	typedef struct packed {
		logic capture;
		logic load_wr;
		logic rev_init;
		logic swap_rd;
		logic swap_wl;
		logic swap_wh;
		logic inv_step;
		logic res_rd;
		logic res_cap;
	} tsr_cmd_t;

	typedef struct packed {
		logic is_load;
		logic is_reverse;
		logic rev_noop;
		logic swap_more;
		logic inv_more;
		logic inv_busy;
		logic out_full;
	} tsr_status_t;

endpackage

>>> rtl/core/tsr_channels.sv
// Valid/ready channel interfaces for the input item and the result beat.
// Depends on tsr_pkg.
`timescale 1ns / 1ps

interface tsr_in_if import tsr_pkg::*; ();
	logic         valid;
	logic         ready;
	logic [1:0]   mode;
	field_t       first_position;
	field_t       second_position;
	field_t       city;

	modport source (output valid, output mode, output first_position,
		output second_position, output city, input ready);
	modport sink (input valid, input mode, input first_position,
		input second_position, input city, output ready);
endinterface

interface tsr_out_if import tsr_pkg::*; ();
	logic   valid;
	logic   ready;
	field_t city_at_position;
	field_t position_of_city;

	modport source (output valid, output city_at_position, output position_of_city,
		input ready);
	modport sink (input valid, input city_at_position, input position_of_city,
		output ready);
endinterface

>>> rtl/core/tsr_ctrl.sv
// Sequencer for load, reversal and result steps of the tour block.
// Depends on tsr_pkg; drives the datapath through tsr_cmd_t.
`timescale 1ns / 1ps

module tsr_ctrl import tsr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  tsr_status_t status,
	output tsr_cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (status.is_load) begin
						state_d = ST_LOAD;
					end else if (status.is_reverse) begin
						state_d = ST_REV_INIT;
					end else begin
						state_d = ST_RES_RD;
					end
				end
			end
			ST_LOAD: begin
				cmd.load_wr = 1'b1;
				state_d     = ST_RES_RD;
			end
			ST_REV_INIT: begin
				cmd.rev_init = 1'b1;
				state_d      = ST_SWAP_RD;
			end
			ST_SWAP_RD: begin
				if (status.rev_noop) begin
					state_d = ST_RES_RD;
				end else if (status.swap_more) begin
					cmd.swap_rd = 1'b1;
					state_d     = ST_SWAP_WL;
				end else begin
					state_d = ST_INV;
				end
			end
			ST_SWAP_WL: begin
				cmd.swap_wl = 1'b1;
				state_d     = ST_SWAP_WH;
			end
			ST_SWAP_WH: begin
				cmd.swap_wh = 1'b1;
				state_d     = ST_SWAP_RD;
			end
			ST_INV: begin
				cmd.inv_step = 1'b1;
				if (!status.inv_more && !status.inv_busy) begin
					state_d = ST_RES_RD;
				end
			end
			ST_RES_RD: begin
				cmd.res_rd = 1'b1;
				state_d    = ST_RES_CAP;
			end
			ST_RES_CAP: begin
				if (!status.out_full) begin
					cmd.res_cap = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/core/tsr_datapath.sv
// Tour and inverse tables, walk pointers and the result register.
// Depends on tsr_pkg; controlled by tsr_ctrl through tsr_cmd_t.
`timescale 1ns / 1ps

module tsr_datapath import tsr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  tsr_cmd_t    cmd,
	output tsr_status_t status,
	input  logic [1:0]  mode,
	input  field_t      first_position,
	input  field_t      second_position,
	input  field_t      city,
	input  logic        out_ready,
	output logic        out_valid,
	output field_t      city_at_position,
	output field_t      position_of_city
);

	field_t tour_mem [TBL_DEPTH];
	field_t inverse_mem [TBL_DEPTH];

	field_t pos_i_q, pos_j_q, city_q;
	field_t hi_q, l_q, h_q, p_q;
	logic   rev_noop_q;
	field_t p_s1;
	logic   inv_pend_s1;
	field_t tour_rd_a_q, tour_rd_b_q, inv_rd_q;
	logic   out_valid_q;
	field_t city_out_q, pos_out_q;

	logic   pos_ok, city_ok, load_ok;
	field_t lo, hi;
	logic   tour_we, tour_re_a;
	field_t tour_wa, tour_wd, tour_ra;
	logic   inv_we;
	field_t inv_wa, inv_wd;

	assign pos_ok  = pos_i_q <= MAX_FIELD;
	assign city_ok = city_q <= MAX_FIELD;
	assign load_ok = cmd.load_wr && pos_ok && city_ok;
	assign lo      = (pos_i_q < pos_j_q) ? pos_i_q : pos_j_q;
	assign hi      = (pos_i_q < pos_j_q) ? pos_j_q : pos_i_q;

	assign status.is_load    = mode == MODE_LOAD;
	assign status.is_reverse = mode == MODE_REVERSE;
	assign status.rev_noop   = rev_noop_q;
	assign status.swap_more  = l_q < h_q;
	assign status.inv_more   = p_q <= hi_q;
	assign status.inv_busy   = inv_pend_s1;
	assign status.out_full   = out_valid_q;

	always_comb begin
		tour_we = load_ok || cmd.swap_wl || cmd.swap_wh;
		if (cmd.load_wr) begin
			tour_wa = pos_i_q;
			tour_wd = city_q;
		end else if (cmd.swap_wl) begin
			tour_wa = l_q;
			tour_wd = tour_rd_b_q;
		end else begin
			tour_wa = h_q;
			tour_wd = tour_rd_a_q;
		end

		tour_re_a = cmd.swap_rd || (cmd.inv_step && status.inv_more)
			|| (cmd.res_rd && pos_ok);
		if (cmd.swap_rd) begin
			tour_ra = l_q;
		end else if (cmd.inv_step) begin
			tour_ra = p_q;
		end else begin
			tour_ra = pos_i_q;
		end

		// inverse write from the walk pipeline skips out-of-range cities
		inv_we = load_ok || (inv_pend_s1 && tour_rd_a_q <= MAX_FIELD);
		if (cmd.load_wr) begin
			inv_wa = city_q;
			inv_wd = pos_i_q;
		end else begin
			inv_wa = tour_rd_a_q;
			inv_wd = p_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (tour_we) begin
			tour_mem[IDX_W'(tour_wa)] <= tour_wd;
		end
		if (tour_re_a) begin
			tour_rd_a_q <= tour_mem[IDX_W'(tour_ra)];
		end
		if (cmd.swap_rd) begin
			tour_rd_b_q <= tour_mem[IDX_W'(h_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (inv_we) begin
			inverse_mem[IDX_W'(inv_wa)] <= inv_wd;
		end
		if (cmd.res_rd && city_ok) begin
			inv_rd_q <= inverse_mem[IDX_W'(city_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pos_i_q <= first_position;
			pos_j_q <= second_position;
			city_q  <= city;
		end
		if (cmd.rev_init) begin
			hi_q       <= hi;
			l_q        <= lo + field_t'(1);
			h_q        <= hi;
			p_q        <= lo + field_t'(1);
			rev_noop_q <= (hi > MAX_FIELD) || (lo == hi);
		end
		if (cmd.swap_wh) begin
			l_q <= l_q + field_t'(1);
			h_q <= h_q - field_t'(1);
		end
		if (cmd.inv_step && status.inv_more) begin
			p_q  <= p_q + field_t'(1);
			p_s1 <= p_q;
		end
		if (cmd.res_cap) begin
			city_out_q <= pos_ok ? tour_rd_a_q : '0;
			pos_out_q  <= city_ok ? inv_rd_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_pend_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			inv_pend_s1 <= cmd.inv_step && status.inv_more;
			if (cmd.res_cap) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign city_at_position = city_out_q;
	assign position_of_city = pos_out_q;

endmodule

>>> rtl/core/tour_segment_reversal.sv
// Tour table with 2-opt segment reversal: one item in, one result beat out.
// Depends on tsr_pkg, tsr_channels, tsr_ctrl and tsr_datapath.
// Takes one item at a time. A reversal over a span of n = hi - lo entries swaps its
// floor(n/2) entry pairs through the single write port of the tour memory, followed
// by a one-entry-per-cycle pass that rewrites the inverse table; a reversal that
// changes nothing skips both. The next item is taken in the cycle after the result
// is captured. Both tables are 1025 x 11 memories with no clearing pass; an entry
// must be loaded before it is read. A finished result waits in an output register,
// and the next item is taken while it waits; that item's result is held back until
// the waiting beat leaves.
`timescale 1ns / 1ps

module tour_segment_reversal import tsr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	tsr_in_if.sink     items,
	tsr_out_if.source  results
);

	tsr_cmd_t    cmd;
	tsr_status_t status;
	logic        ready;

	assign items.ready = ready;

	tsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_ready (ready),
		.status   (status),
		.cmd      (cmd)
	);

	tsr_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.mode             (items.mode),
		.first_position   (items.first_position),
		.second_position  (items.second_position),
		.city             (items.city),
		.out_ready        (results.ready),
		.out_valid        (results.valid),
		.city_at_position (results.city_at_position),
		.position_of_city (results.position_of_city)
	);

endmodule

>>> rtl/core/tsr_checker.sv
// Port-level checks for tour_segment_reversal, bound to the top level.
// Depends on tsr_pkg and tour_segment_reversal_defines.svh.
`timescale 1ns / 1ps
`include "tour_segment_reversal_defines.svh"

module tsr_checker import tsr_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   in_valid,
	input logic   in_ready,
	input logic   out_valid,
	input logic   out_ready,
	input field_t city_at_position,
	input field_t position_of_city
);

	`TSR_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input taken while busy")
	`TSR_ASSERT_IMPL(a_result_from_work, $rose(out_valid), !$past(in_ready), "result beat without work")
	`TSR_ASSERT_IMPL(a_idle_after_result, $rose(out_valid), in_ready, "not idle after result")
	`TSR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(city_at_position) && $stable(position_of_city), "stalled result beat changed")

endmodule

bind tour_segment_reversal tsr_checker u_tsr_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (items.valid),
	.in_ready         (items.ready),
	.out_valid        (results.valid),
	.out_ready        (results.ready),
	.city_at_position (results.city_at_position),
	.position_of_city (results.position_of_city)
);

>>> tb/tour_segment_reversal_tb.sv
// Self-checking bench for tour_segment_reversal: loads, 2-opt reversals and queries
// against a local copy of both tables. Depends on tsr_pkg, tsr_channels and the RTL.
`timescale 1ns / 1ps

module tour_segment_reversal_tb;
	import tsr_pkg::*;

	localparam int         LIMIT_CYCLES  = 10_000_000;
	localparam int         IDLE_PCT      = 27;
	localparam int         BURST_ITEMS   = 100;
	localparam int         MIXED_ITEMS   = 460;
	localparam int         REGION_CAP    = 128;
	localparam int         DRAIN_CYCLES  = 400;
	localparam int         MAX_REPORTS   = 50;
	localparam int         FIELD_TOP     = (1 << FIELD_W) - 1;
	localparam logic [1:0] MODE_SPARE    = 2'd3;

	typedef struct packed {
		field_t city_at_position;
		field_t position_of_city;
	} lookup_t;

	logic clk;
	logic arst_n;

	tsr_in_if  items_if ();
	tsr_out_if results_if ();

	tour_segment_reversal dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_if),
		.results (results_if)
	);

	field_t  tour_copy [0:MAX_CITIES];
	field_t  place_of [0:MAX_CITIES];
	bit      pos_loaded [0:MAX_CITIES];
	bit      city_loaded [0:MAX_CITIES];
	int      known_cities [$];
	int      region_end;
	lookup_t expected_lookups [$];
	bit      quiet;
	int      mismatches;
	int      cycle_count;
	int      n_loads, n_reversals, n_queries, n_results, widest_span;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_REPORTS)
			$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic apply_tour_item(input logic [1:0] mode, input int fp, input int sp,
		input int c);
		int      lo, hi, l, h, p;
		field_t  t;
		lookup_t res;
		if (mode == MODE_LOAD) begin
			if (fp <= MAX_CITIES && c <= MAX_CITIES) begin
				tour_copy[fp] = field_t'(c);
				place_of[c]   = field_t'(fp);
				pos_loaded[fp] = 1'b1;
				if (!city_loaded[c]) begin
					city_loaded[c] = 1'b1;
					known_cities.push_back(c);
				end
				while (region_end <= MAX_CITIES && pos_loaded[region_end])
					region_end++;
			end
		end else if (mode == MODE_REVERSE) begin
			lo = (fp < sp) ? fp : sp;
			hi = (fp < sp) ? sp : fp;
			if (hi <= MAX_CITIES && lo != hi) begin
				if (hi - lo > widest_span)
					widest_span = hi - lo;
				l = lo + 1;
				h = hi;
				while (l < h) begin
					t = tour_copy[l];
					tour_copy[l] = tour_copy[h];
					tour_copy[h] = t;
					l++;
					h--;
				end
				for (p = lo + 1; p <= hi; p++)
					if (tour_copy[p] <= MAX_FIELD)
						place_of[tour_copy[p]] = field_t'(p);
			end
		end
		res.city_at_position = (fp <= MAX_CITIES) ? tour_copy[fp] : '0;
		res.position_of_city = (c <= MAX_CITIES) ? place_of[c] : '0;
		expected_lookups.push_back(res);
	endtask

	// never touch a table entry that has not been loaded
	function automatic bit is_legal(input logic [1:0] mode, input int fp, input int sp,
		input int c);
		int lo, hi, p;
		if (mode == MODE_LOAD && fp <= MAX_CITIES && c <= MAX_CITIES)
			return 1'b1;
		if (fp <= MAX_CITIES && !pos_loaded[fp])
			return 1'b0;
		if (c <= MAX_CITIES && !city_loaded[c])
			return 1'b0;
		if (mode == MODE_REVERSE) begin
			lo = (fp < sp) ? fp : sp;
			hi = (fp < sp) ? sp : fp;
			if (hi <= MAX_CITIES)
				for (p = lo + 1; p <= hi; p++)
					if (!pos_loaded[p])
						return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic send_item(input logic [1:0] mode, input int fp, input int sp, input int c);
		if (!quiet && $urandom_range(99) < IDLE_PCT) begin
			items_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
		end
		items_if.valid           <= 1'b1;
		items_if.mode            <= mode;
		items_if.first_position  <= field_t'(fp);
		items_if.second_position <= field_t'(sp);
		items_if.city            <= field_t'(c);
		do @(posedge clk); while (!items_if.ready);
		apply_tour_item(mode, fp, sp, c);
		case (mode)
			MODE_LOAD:    n_loads++;
			MODE_REVERSE: n_reversals++;
			default:      n_queries++;
		endcase
	endtask

	task automatic pick_position(output int fp);
		case ($urandom_range(9))
			0:       fp = MAX_CITIES - 4 + $urandom_range(4);
			1:       fp = $urandom_range(FIELD_TOP);
			default: fp = $urandom_range(region_end - 1);
		endcase
	endtask

	task automatic random_item(output logic [1:0] mode, output int fp, output int sp,
		output int c);
		int roll;
		do begin
			roll = $urandom_range(99);
			sp   = $urandom_range(FIELD_TOP);
			c    = known_cities[$urandom_range(known_cities.size() - 1)];
			if ($urandom_range(19) == 0)
				c = MAX_CITIES + 1 + $urandom_range(FIELD_TOP - MAX_CITIES - 1);
			if (roll < 30) begin
				mode = MODE_LOAD;
				c    = $urandom_range(MAX_CITIES);
				case ($urandom_range(9))
					0, 1, 2, 3: fp = (region_end < REGION_CAP) ? region_end
						: $urandom_range(region_end - 1);
					4:          fp = MAX_CITIES - 10 + $urandom_range(10);
					default:    fp = $urandom_range(region_end - 1);
				endcase
			end else if (roll < 75) begin
				mode = MODE_REVERSE;
				fp   = $urandom_range(region_end - 1);
				case ($urandom_range(9))
					0:          begin
						fp = MAX_CITIES - 5 + $urandom_range(5);
						sp = MAX_CITIES - 5 + $urandom_range(5);
					end
					1:          sp = $urandom_range(FIELD_TOP);
					2, 3, 4, 5: sp = fp + $urandom_range(8) - 4;
					default:    sp = $urandom_range(region_end - 1);
				endcase
				if (sp < 0)
					sp = 0;
			end else if (roll < 92) begin
				mode = ($urandom_range(3) == 0) ? MODE_SPARE : MODE_QUERY;
				pick_position(fp);
			end else begin
				mode = 2'($urandom_range(3));
				fp   = $urandom_range(FIELD_TOP);
				c    = $urandom_range(FIELD_TOP);
			end
		end while (!is_legal(mode, fp, sp, c));
	endtask

	task automatic test_loads();
		int cities [10] = '{0, MAX_CITIES, 5, 17, 512, 333, 1023, 64, 700, 1};
		for (int i = 0; i < 10; i++)
			send_item(MODE_LOAD, i, $urandom_range(FIELD_TOP), cities[i]);
		send_item(MODE_LOAD, MAX_CITIES - 2, 0, 2);
		send_item(MODE_LOAD, MAX_CITIES - 1, FIELD_TOP, 3);
		send_item(MODE_LOAD, MAX_CITIES, 0, 4);
	endtask

	task automatic test_reversal_cases();
		send_item(MODE_REVERSE, 2, 7, 17);
		send_item(MODE_REVERSE, 8, 3, 512);
		send_item(MODE_REVERSE, 5, 5, 333);
		send_item(MODE_REVERSE, 0, 9, 0);
		send_item(MODE_REVERSE, MAX_CITIES - 2, MAX_CITIES, 4);
		send_item(MODE_REVERSE, MAX_CITIES, MAX_CITIES - 1, MAX_CITIES);
		send_item(MODE_REVERSE, 4, FIELD_TOP, 5);
		send_item(MODE_REVERSE, FIELD_TOP, 3, 1);
	endtask

	task automatic test_odd_inputs();
		send_item(MODE_QUERY, 6, 0, 1023);
		send_item(MODE_SPARE, 7, FIELD_TOP, 64);
		send_item(MODE_LOAD, FIELD_TOP, 0, 700);
		send_item(MODE_LOAD, 3, 0, FIELD_TOP);
		send_item(MODE_QUERY, 2000, 0, 1500);
	endtask

	task automatic run_random(input int count);
		logic [1:0] mode;
		int         fp, sp, c;
		repeat (count) begin
			random_item(mode, fp, sp, c);
			send_item(mode, fp, sp, c);
		end
	endtask

	task automatic test_back_to_back();
		quiet = 1'b1;
		run_random(BURST_ITEMS);
		quiet = 1'b0;
	endtask

	task automatic test_random_mix();
		run_random(MIXED_ITEMS);
	endtask

	initial begin
		lookup_t want;
		results_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && results_if.valid && results_if.ready) begin
				if (expected_lookups.size() == 0) begin
					report_mismatch("result beat with nothing expected");
				end else begin
					want = expected_lookups.pop_front();
					n_results++;
					if (results_if.city_at_position !== want.city_at_position)
						report_mismatch($sformatf("city_at_position %0d, expected %0d",
							results_if.city_at_position, want.city_at_position));
					if (results_if.position_of_city !== want.position_of_city)
						report_mismatch($sformatf("position_of_city %0d, expected %0d",
							results_if.position_of_city, want.position_of_city));
				end
			end
			results_if.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count <= LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
			expected_lookups.size());
		$display("simulation failed");
		$finish;
	end

	initial begin
		quiet       = 1'b0;
		mismatches  = 0;
		region_end  = 0;
		n_loads     = 0;
		n_reversals = 0;
		n_queries   = 0;
		n_results   = 0;
		widest_span = 0;
		for (int i = 0; i <= MAX_CITIES; i++) begin
			pos_loaded[i]  = 1'b0;
			city_loaded[i] = 1'b0;
		end
		arst_n                   <= 1'b0;
		items_if.valid           <= 1'b0;
		items_if.mode            <= MODE_QUERY;
		items_if.first_position  <= '0;
		items_if.second_position <= '0;
		items_if.city            <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_loads();
		test_reversal_cases();
		test_odd_inputs();
		test_back_to_back();
		test_random_mix();

		items_if.valid <= 1'b0;
		while (expected_lookups.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d loads, %0d reversals (widest span %0d), %0d queries",
			n_loads, n_reversals, widest_span, n_queries);
		$display("checked %0d result beats, %0d mismatches", n_results, mismatches);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> tour_segment_reversal.f
+incdir+rtl/core
rtl/core/tsr_pkg.sv
rtl/core/tsr_channels.sv
rtl/core/tsr_ctrl.sv
rtl/core/tsr_datapath.sv
rtl/core/tour_segment_reversal.sv
rtl/core/tsr_checker.sv
tb/tour_segment_reversal_tb.sv
